// ----- hw/rtl/sha_pkg.sv -----
// SHA-256 package: round constants, initial hash values, mixing functions.
// Used by every module of the stream hasher; no dependencies.
package sha_pkg;
	localparam int unsigned BlockBytes = 64;
	localparam int unsigned QueueDepth = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       finish;
	} sha_req_t;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		begin
			case (i)
				6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
				6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
				6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
				6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
				6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
				6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
				6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
				6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
				6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
				6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
				6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
				6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
				6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
				6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
				6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
				6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
				6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
				6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
				6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
				6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
				6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
				default: k = 32'hc67178f2;
			endcase
			return k;
		end
	endfunction

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] h;
		begin
			case (i)
				3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
				3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
				3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
				3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
			endcase
			return h;
		end
	endfunction

	function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction
endpackage

// ----- hw/rtl/sha_req_fifo.sv -----
// Request queue between the byte front end and the compression back end.
// Depends on sha_pkg.
module sha_req_fifo #(
	parameter int unsigned DEPTH = sha_pkg::QueueDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sha_pkg::sha_req_t in_req,
	output logic              out_valid,
	input  logic              out_ready,
	output sha_pkg::sha_req_t out_req
);
	import sha_pkg::*;
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	sha_req_t           mem_q [DEPTH];
	logic [AW-1:0]      wr_q, rd_q;
	logic [AW:0]        cnt_q;
	logic               push, pop;

	assign in_ready  = (cnt_q != (AW+1)'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_req   = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH)) else $error("queue count beyond depth");
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("push lost");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 1'b1) else $error("pop lost");
endmodule

// ----- hw/rtl/sha_core.sv -----
// Back end: block buffer, message schedule, 64-round compression, padding, digest output.
// Depends on sha_pkg.
module sha_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  sha_pkg::sha_req_t req,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       digest_word,
	output logic [2:0]        word_index,
	output logic              last_word
);
	import sha_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_ADD, ST_OUT
	} state_t;

	state_t       state_q;
	// bytes shift in at the bottom; after 64 of them byte 0 sits in the top bits
	logic [8*BlockBytes-1:0] blk_q;
	logic [31:0]  h_q [8];
	logic [31:0]  w_q [16];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
	logic [63:0]  bits_q;
	logic [5:0]   pos_q;
	logic [5:0]   rnd_q;
	logic [2:0]   oidx_q;
	logic         fin_q;   // compression belongs to finalization
	logic         len_q;   // 0x80 marker written
	logic         lenw_q;  // length bytes written, digest follows this compression
	logic         spill_q; // marker landed past byte 55: zero this block, length goes next
	logic [31:0]  wnew, t1, t2, s0, s1, big0, big1, ch, maj;
	logic [31:0]  dig_q;
	logic         ov_q;

	always_comb begin
		s0   = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
		s1   = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
		wnew = s1 + w_q[9] + s0 + w_q[0];
		big1 = ror(e_q, 6) ^ ror(e_q, 11) ^ ror(e_q, 25);
		ch   = (e_q & f_q) ^ (~e_q & g_q);
		t1   = hh_q + big1 + ch + round_k(rnd_q) + w_q[0];
		big0 = ror(a_q, 2) ^ ror(a_q, 13) ^ ror(a_q, 22);
		maj  = (a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q);
		t2   = big0 + maj;
	end

	assign req_ready   = (state_q == ST_IDLE);
	assign out_valid   = ov_q;
	assign digest_word = dig_q;
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bits_q  <= '0;
			pos_q   <= '0;
			rnd_q   <= '0;
			oidx_q  <= '0;
			fin_q   <= 1'b0;
			len_q   <= 1'b0;
			lenw_q  <= 1'b0;
			spill_q <= 1'b0;
			ov_q    <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						fin_q   <= req.finish;
						len_q   <= 1'b0;
						lenw_q  <= 1'b0;
						spill_q <= 1'b0;
						if (req.byte_valid) begin
							blk_q  <= {blk_q[8*BlockBytes-9:0], req.data_byte};
							bits_q <= bits_q + 64'd8;
							pos_q  <= pos_q + 1'b1;
						end
						if (req.byte_valid && pos_q == 6'd63) state_q <= ST_LOAD;
						else if (req.finish) state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					// write 0x80, zero fill, length; one byte a cycle
					pos_q <= pos_q + 1'b1;
					if (!len_q) begin
						blk_q   <= {blk_q[8*BlockBytes-9:0], 8'h80};
						len_q   <= 1'b1;
						spill_q <= (pos_q > 6'd55);
						if (pos_q == 6'd63) state_q <= ST_LOAD;
					end else if (spill_q || pos_q < 6'd56) begin
						blk_q <= {blk_q[8*BlockBytes-9:0], 8'h00};
						if (pos_q == 6'd63) state_q <= ST_LOAD;
					end else begin
						blk_q <= {blk_q[8*BlockBytes-9:0], bits_q[8*(7-pos_q[2:0]) +: 8]};
						if (pos_q == 6'd63) begin
							lenw_q  <= 1'b1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					for (int i = 0; i < 16; i++)
						w_q[i] <= blk_q[8*BlockBytes-1-32*i -: 32];
					a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
					e_q <= h_q[4]; f_q <= h_q[5]; g_q <= h_q[6]; hh_q <= h_q[7];
					rnd_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= wnew;
					hh_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
					d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q; h_q[5] <= h_q[5] + f_q;
					h_q[6] <= h_q[6] + g_q; h_q[7] <= h_q[7] + hh_q;
					oidx_q <= '0;
					if (!fin_q) state_q <= ST_IDLE;
					else if (lenw_q) state_q <= ST_OUT;
					else begin
						spill_q <= 1'b0;
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (!ov_q || out_ready) begin
						if (ov_q && oidx_q == 3'd7) begin
							ov_q <= 1'b0;
							bits_q <= '0;
							pos_q <= '0;
							for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
							state_q <= ST_IDLE;
						end else begin
							dig_q <= h_q[ov_q ? oidx_q + 1'b1 : oidx_q];
							if (ov_q) oidx_q <= oidx_q + 1'b1;
							ov_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_out_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(word_index)) else $error("index moved under stall");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> !req_ready) else $error("accepted during rounds");
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND && rnd_q == 6'd63 |=> state_q == ST_ADD) else $error("round count");
endmodule

// ----- hw/rtl/sha256_stream_hasher.sv -----
// Top level of the streaming SHA-256 hasher: request queue feeding the compression core.
// Depends on sha_pkg, sha_req_fifo, sha_core.
// A byte request is accepted only while the core is idle. The 64th byte of a block starts
// schedule load, 64 rounds at one per cycle, hash add. A finish request writes padding and
// length one byte a cycle, runs one or two compressions, then presents eight digest words,
// word 0 first, one per accepted cycle. Up to QUEUE_DEPTH (default 4) requests queue ahead.
module sha256_stream_hasher #(
	parameter int unsigned QUEUE_DEPTH = sha_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        finish,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha_pkg::*;

	sha_req_t in_req, q_req;
	logic     q_valid, q_ready;

	assign in_req = '{data_byte: data_byte, byte_valid: byte_valid, finish: finish};

	sha_req_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk, .arst_n, .in_valid, .in_ready, .in_req,
		.out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
	);

	sha_core u_core (
		.clk, .arst_n, .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
		.out_valid, .out_ready, .digest_word, .word_index, .last_word
	);
endmodule

// ----- tb/sha256_stream_hasher_tb.sv -----
// Testbench for the streaming SHA-256 hasher: drives byte/finish requests and checks digest words.
// Depends on sha_pkg and sha256_stream_hasher; the digest is predicted by a local SHA-256 model.
module sha256_stream_hasher_tb;
	import sha_pkg::*;

	localparam int unsigned STALL_LIMIT = 20000;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        byte_valid;
	logic        finish;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	sha256_stream_hasher dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .byte_valid(byte_valid), .finish(finish),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	// predictor state
	logic [31:0] hash_state [8];
	logic [7:0]  msg_block [64];
	logic [63:0] msg_bits;
	digest_t     pending_digest [$];

	int  errors;
	int  idle_cycles;
	bit  stim_done;

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	localparam logic [31:0] StartH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_msg_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
				+ (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
		for (int i = 0; i < 8; i++)
			v[i] = hash_state[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] += v[i];
	endtask

	task automatic restart_hash();
		for (int i = 0; i < 8; i++)
			hash_state[i] = StartH[i];
		msg_bits = '0;
	endtask

	task automatic predict_digest(input sha_req_t req);
		int pos;
		digest_t d;
		if (req.byte_valid) begin
			pos = int'(msg_bits[8:3]);
			msg_block[pos] = req.data_byte;
			msg_bits += 64'd8;
			if (pos == 63)
				compress_msg_block();
		end
		if (!req.finish)
			return;
		pos = int'(msg_bits[8:3]);
		msg_block[pos] = 8'h80;
		pos++;
		if (pos > 56) begin
			while (pos < 64) begin
				msg_block[pos] = 8'h00;
				pos++;
			end
			compress_msg_block();
			pos = 0;
		end
		while (pos < 56) begin
			msg_block[pos] = 8'h00;
			pos++;
		end
		for (int i = 0; i < 8; i++)
			msg_block[56+i] = msg_bits[63-8*i -: 8];
		compress_msg_block();
		for (int i = 0; i < 8; i++) begin
			d.word = hash_state[i];
			d.idx = 3'(i);
			d.last = (i == 7);
			pending_digest.push_back(d);
		end
		restart_hash();
	endtask

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// hold the request until accepted; the predictor runs at acceptance
	task automatic send_request(input logic [7:0] b, input logic bv, input logic fin);
		sha_req_t req;
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
		if ($urandom_range(0, 4) == 0)
			gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		byte_valid <= bv;
		finish <= fin;
		do
			@(posedge clk);
		while (!in_ready);
		req = '{data_byte: b, byte_valid: bv, finish: fin};
		predict_digest(req);
	endtask

	// drop valid, then hold until every predicted word has been received
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_digest.size() != 0);
	endtask

	task automatic send_message(input int len, input logic fin_with_last);
		for (int i = 0; i < len; i++)
			send_request(8'($urandom), 1'b1, fin_with_last && (i == len - 1));
		if (!fin_with_last || len == 0)
			send_request(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic test_empty_message();
		send_request(8'h00, 1'b0, 1'b1);
		send_request(8'hff, 1'b0, 1'b1);
	endtask

	task automatic test_field_extremes();
		send_request(8'h00, 1'b1, 1'b0);
		send_request(8'hff, 1'b1, 1'b0);
		send_request(8'haa, 1'b0, 1'b0);
		send_request(8'h55, 1'b1, 1'b1);
		send_request(8'hff, 1'b1, 1'b1);
		send_request(8'h00, 1'b0, 1'b0);
		send_request(8'h00, 1'b1, 1'b1);
	endtask

	// 56 bytes push the length into a second block; 64 ends a block with the finishing byte
	task automatic test_pad_boundaries();
		send_message(56, 1'b1);
		wait_drained();
		send_message(64, 1'b1);
	endtask

	task automatic test_random_stream();
		int sent;
		int len;
		sent = 0;
		while (sent < 40) begin
			case ($urandom_range(0, 9))
				0: begin
					send_request(8'($urandom), 1'($urandom), 1'b0);
					sent++;
				end
				1: begin
					wait_drained();
					send_request(8'($urandom), 1'b0, 1'b1);
					sent++;
				end
				default: begin
					len = $urandom_range(0, 12);
					send_message(len, 1'($urandom));
					sent += len + 1;
				end
			endcase
		end
	endtask

	initial begin
		clk = 1'b0;
		errors = 0;
		stim_done = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		byte_valid = 1'b0;
		finish = 1'b0;
		restart_hash();
		for (int i = 0; i < 64; i++)
			msg_block[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_message();
		test_field_extremes();
		test_pad_boundaries();
		wait_drained();
		test_random_stream();
		wait_drained();
		stim_done = 1'b1;
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_digest.size() == 0)
			$display("[sha256_stream_hasher] OK");
		else
			$display("[sha256_stream_hasher] ERROR");
		$finish;
	end

	// receiver: random stall per word, some stretches without stalls
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
		end
	end

	always @(posedge clk) begin
		digest_t exp_d;
		if (arst_n && out_valid && out_ready) begin
			if (pending_digest.size() == 0) begin
				$display("%0t: expected no digest word, actual %h index %0d", $time,
					digest_word, word_index);
				errors++;
			end else begin
				exp_d = pending_digest.pop_front();
				if (digest_word !== exp_d.word) begin
					$display("%0t: digest_word expected %h actual %h", $time, exp_d.word,
						digest_word);
					errors++;
				end
				if (word_index !== exp_d.idx) begin
					$display("%0t: word_index expected %0d actual %0d", $time, exp_d.idx,
						word_index);
					errors++;
				end
				if (last_word !== exp_d.last) begin
					$display("%0t: last_word expected %b actual %b", $time, exp_d.last,
						last_word);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles with no handshake on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT && !stim_done) begin
			$display("[sha256_stream_hasher] ERROR");
			$finish;
		end
	end

endmodule
